@@ rtl/core/sha_pkg.sv @@
// SHA-256 hasher package: payload types, round constants, initial hash and sigma functions.
`timescale 1ns / 1ps

package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  widx_t;

  // Input beat kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam byte_t PAD_BYTE = 8'h80;

  // Initial hash value
  localparam word_t SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam word_t SHA_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Compression sigmas
  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Message schedule sigmas
  function automatic word_t sml_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ rtl/core/sha_in_if.sv @@
// Input channel: message byte or end-of-message beat.
`timescale 1ns / 1ps

interface sha_in_if import sha_pkg::*;;
  logic  valid;
  logic  ready;
  logic  kind;
  byte_t data_byte;

  modport source(output valid, kind, data_byte, input ready);
  modport sink(input valid, kind, data_byte, output ready);
endinterface

@@ rtl/core/sha_out_if.sv @@
// Result channel: one digest word per beat.
`timescale 1ns / 1ps

interface sha_out_if import sha_pkg::*;;
  logic  valid;
  logic  ready;
  word_t digest_word;
  widx_t word_index;
  logic  last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream: block buffer, round sequencer and digest output.
`timescale 1ns / 1ps

// SHA-256 byte-stream hasher. Message bytes are taken one per cycle while
// ready into a 512-bit block shift register; the 64th byte of a block starts
// the compression, which runs one round per cycle on a single round unit and
// then folds into the hash state. An end-of-message beat pads in place, one
// byte per cycle (0x80, zero fill, the 64-bit big-endian bit length),
// compressing one extra block when fewer than nine bytes were free, and then
// presents the eight digest words, word 0 first, last_word set on word 7.
// The block is not ready for input during padding, compression or output.
// After the last word the hash state and length counter return to their
// initial values.
module sha256_byte_stream_hasher import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]   state_r;
  logic [511:0] blk_r;       // byte buffer, then message schedule window
  word_t        chain_r [0:7];
  word_t        v_r [0:7];
  logic [5:0]   fill_r;
  logic [63:0]  msg_bits_r;
  logic [5:0]   round_r;
  widx_t        idx_r;
  logic         pad_first_r;
  logic         len_ok_r;    // length fits in the current padded block
  logic         end_r;       // end-of-message handling in progress

  word_t w0, w1, w9, w14, w_new;
  word_t t1, t2, e_ch, a_maj;
  byte_t len_byte, pad_byte;
  logic [5:0] len_sel;

  // Schedule window taps, word 0 in the top bits
  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign w_new = sml_sig1(w14) + w9 + sml_sig0(w1) + w0;

  // Round unit
  assign e_ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign a_maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + big_sig1(v_r[4]) + e_ch + SHA_K[round_r] + w0;
  assign t2 = big_sig0(v_r[0]) + a_maj;

  // Padding byte: marker, zeros, then length bytes MSB first
  assign len_sel  = {3'(3'd7 - fill_r[2:0]), 3'b000};
  assign len_byte = msg_bits_r[len_sel +: 8];

  always_comb begin
    if (pad_first_r) begin
      pad_byte = PAD_BYTE;
    end else if (len_ok_r && (fill_r >= 6'd56)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Handshake outputs
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.digest_word = chain_r[0];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == 3'd7);

  // Payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && (in_ch.kind == KIND_BYTE)) begin
          blk_r <= {blk_r[503:0], in_ch.data_byte};
          if (fill_r == 6'd63) begin
            v_r <= chain_r;
          end
        end
      end
      ST_PAD: begin
        blk_r <= {blk_r[503:0], pad_byte};
        if (fill_r == 6'd63) begin
          v_r <= chain_r;
        end
      end
      ST_ROUND: begin
        blk_r <= {blk_r[479:0], w_new};
        v_r[0] <= t1 + t2;
        v_r[1] <= v_r[0];
        v_r[2] <= v_r[1];
        v_r[3] <= v_r[2];
        v_r[4] <= v_r[3] + t1;
        v_r[5] <= v_r[4];
        v_r[6] <= v_r[5];
        v_r[7] <= v_r[6];
      end
      default: begin
      end
    endcase
  end

  // Sequencer and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= SHA_IV;
      fill_r      <= 6'd0;
      msg_bits_r  <= 64'd0;
      round_r     <= 6'd0;
      idx_r       <= 3'd0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
      end_r       <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.kind == KIND_END) begin
              state_r     <= ST_PAD;
              pad_first_r <= 1'b1;
              end_r       <= 1'b1;
            end else begin
              fill_r     <= fill_r + 6'd1;
              msg_bits_r <= msg_bits_r + 64'd8;
              if (fill_r == 6'd63) begin
                state_r <= ST_ROUND;
                round_r <= 6'd0;
              end
            end
          end
        end
        ST_PAD: begin
          fill_r      <= fill_r + 6'd1;
          pad_first_r <= 1'b0;
          if (pad_first_r) begin
            len_ok_r <= (fill_r <= 6'd55);
          end
          if (fill_r == 6'd63) begin
            state_r <= ST_ROUND;
            round_r <= 6'd0;
          end
        end
        ST_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) begin
            state_r <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= chain_r[i] + v_r[i];
          end
          if (!end_r) begin
            state_r <= ST_IDLE;
          end else if (len_ok_r) begin
            state_r <= ST_EMIT;
            idx_r   <= 3'd0;
          end else begin
            // overflow block done, length goes in the next one
            len_ok_r <= 1'b1;
            state_r  <= ST_PAD;
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              chain_r    <= SHA_IV;
              fill_r     <= 6'd0;
              msg_bits_r <= 64'd0;
              end_r      <= 1'b0;
              state_r    <= ST_IDLE;
            end else begin
              for (int i = 0; i < 7; i++) begin
                chain_r[i] <= chain_r[i + 1];
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/sha256_hash_checker.sv @@
// Digest checker: watches both channels, predicts SHA-256 digests and compares output beats.
`timescale 1ns / 1ps

module sha256_hash_checker import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sha_in_if           in_mon,
  sha_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned words_pending
);

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned LEN_POS     = 56;

  // FIPS 180-4 initial hash and round constants
  localparam word_t H_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K256 [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    word_t word;
    widx_t idx;
    logic  last;
  } digest_beat_t;

  // Predicted hasher state
  word_t       chain_h [8];
  byte_t       msg_block [64];
  logic [5:0]  block_fill;
  logic [63:0] bit_count;

  digest_beat_t digest_words_q [$];
  int unsigned  mismatch_cnt = 0;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = H_START[i];
    block_fill = '0;
    bit_count  = '0;
  endfunction

  // 64-round compression of msg_block into chain_h
  function automatic void fold_block();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           K256[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void take_byte(input byte_t data);
    msg_block[block_fill] = data;
    bit_count  = bit_count + 64'd8;
    block_fill = block_fill + 6'd1;
    if (block_fill == '0) fold_block();
  endfunction

  // Pad, append length, compress, and queue the eight digest words
  function automatic void finish_message();
    int unsigned pos;
    digest_beat_t beat;
    pos = 32'(block_fill);
    msg_block[pos] = PAD_BYTE;
    pos++;
    // no room for the length: zero out this block and spill into another
    if (pos > LEN_POS) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      fold_block();
      pos = 0;
    end
    while (pos < LEN_POS) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) msg_block[LEN_POS + i] = bit_count[63 - 8*i -: 8];
    fold_block();
    for (int i = 0; i < 8; i++) begin
      beat.word = chain_h[i];
      beat.idx  = widx_t'(i);
      beat.last = (i == 7);
      digest_words_q.push_back(beat);
    end
    restart_hash();
  endfunction

  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst_n) begin
      restart_hash();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      digest_words_q.delete();
      fail_count   = 0;
      mismatch_cnt = 0;
    end else begin
      // input beat: update prediction
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_END) finish_message();
        else take_byte(in_mon.data_byte);
      end
      // output beat: compare against oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (digest_words_q.size() == 0) begin
          fail_count++;
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("[%0t] unexpected digest beat: word %h idx %0d last %0b", $realtime,
                     out_mon.digest_word, out_mon.word_index, out_mon.last_word);
        end else begin
          exp_beat = digest_words_q.pop_front();
          if (out_mon.digest_word !== exp_beat.word || out_mon.word_index !== exp_beat.idx ||
              out_mon.last_word !== exp_beat.last) begin
            fail_count++;
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("[%0t] digest mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                       $realtime, exp_beat.word, exp_beat.idx, exp_beat.last,
                       out_mon.digest_word, out_mon.word_index, out_mon.last_word);
          end
        end
      end
    end
    words_pending = digest_words_q.size();
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top: clock, reset, byte-stream stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top import sha_pkg::*;;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 200;
  // message lengths around the padding boundary and the block edge
  localparam int unsigned EDGE_LENS [4] = '{55, 56, 64, 63};

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_COUNT} fill_style_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned burst_left  = 0;
  int unsigned items_sent  = 0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_byte_stream_hasher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha256_hash_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #6 clk = ~clk;

  // One input beat, with bursty gaps; returns at the accepting edge
  task automatic offer(input logic kind, input byte_t data);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_ch.kind      = kind;
    in_ch.data_byte = data;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop offering until every predicted digest word has come out
  task automatic drain_pause();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len, input fill_style_t style);
    byte_t b;
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        FILL_ZERO:  b = 8'h00;
        FILL_ONES:  b = 8'hFF;
        FILL_COUNT: b = byte_t'(i);
        default:    b = byte_t'($urandom);
      endcase
      offer(KIND_BYTE, b);
    end
    offer(KIND_END, byte_t'($urandom));
  endtask

  // Stimulus and verdict
  initial begin : stim
    int unsigned msg_no, rand_base, len, pick;
    fill_style_t style;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_BYTE;
    in_ch.data_byte = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty messages back to back, "abc", byte extremes
    offer(KIND_END, 8'h00);
    offer(KIND_END, 8'hFF);
    offer(KIND_BYTE, 8'h61); offer(KIND_BYTE, 8'h62); offer(KIND_BYTE, 8'h63);
    offer(KIND_END, 8'h00);
    offer(KIND_BYTE, 8'h00); offer(KIND_BYTE, 8'hFF); offer(KIND_BYTE, PAD_BYTE);
    offer(KIND_END, 8'h5A);
    offer(KIND_BYTE, 8'h55); offer(KIND_BYTE, 8'hAA);
    offer(KIND_END, 8'hA5);
    offer(KIND_BYTE, 8'hFF);
    offer(KIND_END, 8'hFF);
    drain_pause();

    // random messages; output held off for a long stretch near the start
    hold_req  = 1'b1;
    msg_no    = 0;
    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      if (msg_no % 4 == 3) len = EDGE_LENS[(msg_no / 4) % 4];
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(9, 30);
      else len = $urandom_range(0, 8);
      pick  = $urandom_range(0, 7);
      style = (pick < 5) ? FILL_RANDOM : fill_style_t'(pick - 4);
      send_message(len, style);
      if ($urandom_range(0, 5) == 0) drain_pause();
      msg_no++;
    end

    drain_pause();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall segments, one long hold-off when requested
  initial begin : rx_side
    int unsigned seg, mode;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(4, 48);
        for (int unsigned k = 0; k < seg; k++) begin
          @(negedge clk);
          case (mode)
            0:       out_ch.ready = 1'b1;
            1:       out_ch.ready = ($urandom_range(0, 3) != 0);
            2:       out_ch.ready = (k % 3 != 2);
            default: out_ch.ready = $urandom_range(0, 1);
          endcase
        end
      end
    end
  end

  // Watchdog: too long without any accepted beat on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
